[sv/lfu_pkg.sv]
// ----------------------------------------------------------------------------
// LFU cache package
// Shared constants and controller/datapath command and status types.
// ----------------------------------------------------------------------------
`default_nettype none

package lfu_pkg;

    localparam int CAPACITY  = 16;
    localparam int SLOT_W    = $clog2(CAPACITY);
    localparam int FILL_W    = $clog2(CAPACITY + 1);
    localparam int CAP_W     = 5;
    localparam int KEY_W     = 32;
    localparam int VAL_W     = 32;
    localparam int CNT_W     = 16;
    localparam int RANK_W    = SLOT_W;
    localparam int TDATA_IN_W  = 64;
    localparam int TDATA_OUT_W = 64;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam logic [VAL_W-1:0] NEG_ONE   = '1;

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture input beat
        logic lookup;   // register key compare results
        logic search;   // register victim / free slot search
        logic update;   // apply state change and form result
    } lfu_cmd_t;

    // datapath -> controller (unused fields kept minimal)
    typedef struct packed {
        logic done;
    } lfu_sts_t;

endpackage

`default_nettype wire

[sv/lfu_ctrl.sv]
// ----------------------------------------------------------------------------
// LFU cache controller
// Sequences load, lookup, search and update; owns the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output lfu_pkg::lfu_cmd_t    cmd,
    input  wire lfu_pkg::lfu_sts_t sts
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LOOKUP = 4'b0010,
        ST_SEARCH = 4'b0100,
        ST_UPDATE = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   mvalid_reg, mvalid_next;

    // A new beat may enter while the previous result waits; update then holds
    // until the result register frees before it writes it.
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;

    always_comb begin
        state_next  = state_reg;
        mvalid_next = mvalid_reg;
        cmd         = '0;
        if (m_tready) begin
            mvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                cmd.lookup = 1'b1;
                state_next = ST_SEARCH;
            end
            ST_SEARCH: begin
                cmd.search = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (!mvalid_reg || m_tready) begin
                    cmd.update  = 1'b1;
                    mvalid_next = sts.done;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule

`default_nettype wire

[sv/lfu_dpath.sv]
// ----------------------------------------------------------------------------
// LFU cache datapath
// Entry store, parallel key compare, victim search and rank/count update.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_dpath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire lfu_pkg::lfu_cmd_t             cmd,
    output lfu_pkg::lfu_sts_t                  sts,
    input  wire logic                          cfg_wr_en,
    input  wire logic [lfu_pkg::CAP_W-1:0]     cfg_wr_data,
    input  wire logic                          in_func,
    input  wire logic [lfu_pkg::KEY_W-1:0]     in_key,
    input  wire logic [lfu_pkg::VAL_W-1:0]     in_value,
    output logic                               out_hit,
    output logic [lfu_pkg::VAL_W-1:0]          out_read_value,
    output logic                               out_evicted,
    output logic [lfu_pkg::KEY_W-1:0]          out_evicted_key
);

    localparam int N = lfu_pkg::CAPACITY;

    logic [lfu_pkg::CAP_W-1:0]  cap_reg;
    logic [N-1:0]               valid_reg;
    logic [lfu_pkg::KEY_W-1:0]  key_mem_reg  [N];
    logic [lfu_pkg::VAL_W-1:0]  val_mem_reg  [N];
    logic [lfu_pkg::CNT_W-1:0]  cnt_mem_reg  [N];
    logic [lfu_pkg::RANK_W-1:0] rank_mem_reg [N];
    logic [lfu_pkg::FILL_W-1:0] fill_reg;

    logic                       func_reg;
    logic [lfu_pkg::KEY_W-1:0]  key_reg;
    logic [lfu_pkg::VAL_W-1:0]  wval_reg;

    logic                       hit_reg;
    logic [lfu_pkg::SLOT_W-1:0] hslot_reg;
    logic [lfu_pkg::SLOT_W-1:0] vslot_reg;
    logic                       vfound_reg;
    logic [lfu_pkg::SLOT_W-1:0] fslot_reg;
    logic                       ffound_reg;

    logic [N-1:0]               match_c;
    logic                       hit_c;
    logic [lfu_pkg::SLOT_W-1:0] hslot_c;
    logic [lfu_pkg::SLOT_W-1:0] vslot_c, fslot_c;
    logic                       vfound_c, ffound_c;
    logic [lfu_pkg::FILL_W-1:0] cap_eff;

    // victim tournament, heap indexed: leaves at N..2N-1, winner at 1
    logic [lfu_pkg::CNT_W+lfu_pkg::RANK_W:0] vscore [2*N];
    logic [lfu_pkg::SLOT_W-1:0]              vtree  [2*N];

    assign sts.done = 1'b1;
    assign cap_eff = (cap_reg > lfu_pkg::CAP_W'(N)) ? lfu_pkg::FILL_W'(N)
                                                    : lfu_pkg::FILL_W'(cap_reg);

    // parallel compare
    always_comb begin
        hit_c   = 1'b0;
        hslot_c = '0;
        for (int i = 0; i < N; i++) begin
            match_c[i] = valid_reg[i] && (key_mem_reg[i] == key_reg);
        end
        for (int i = N - 1; i >= 0; i--) begin
            if (match_c[i]) begin
                hit_c   = 1'b1;
                hslot_c = lfu_pkg::SLOT_W'(i);
            end
        end
    end

    // victim: lowest count, then oldest rank; free slot: lowest invalid
    // score {valid, ~count, rank} is unique among valid entries
    always_comb begin
        vscore[0] = '0;
        vtree[0]  = '0;
        for (int i = 0; i < N; i++) begin
            vscore[N+i] = valid_reg[i] ? {1'b1, ~cnt_mem_reg[i], rank_mem_reg[i]} : '0;
            vtree[N+i]  = lfu_pkg::SLOT_W'(i);
        end
        for (int j = N - 1; j >= 1; j--) begin
            if (vscore[2*j+1] > vscore[2*j]) begin
                vscore[j] = vscore[2*j+1];
                vtree[j]  = vtree[2*j+1];
            end else begin
                vscore[j] = vscore[2*j];
                vtree[j]  = vtree[2*j];
            end
        end
        vfound_c = |valid_reg;
        vslot_c  = vtree[1];
        ffound_c = 1'b0;
        fslot_c  = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                ffound_c = 1'b1;
                fslot_c  = lfu_pkg::SLOT_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= in_func;
            key_reg  <= in_key;
            wval_reg <= in_value;
        end
        if (cmd.lookup) begin
            hit_reg   <= hit_c;
            hslot_reg <= hslot_c;
        end
        if (cmd.search) begin
            vslot_reg  <= vslot_c;
            vfound_reg <= vfound_c;
            fslot_reg  <= fslot_c;
            ffound_reg <= ffound_c;
        end
    end

    // update stage
    logic                       do_touch, do_insert, do_evict;
    logic [lfu_pkg::SLOT_W-1:0] ins_slot;
    logic                       full;

    always_comb begin
        full      = fill_reg >= cap_eff;
        do_touch  = hit_reg && (func_reg == lfu_pkg::FUNC_GET ||
                                cap_eff != '0);
        do_evict  = func_reg == lfu_pkg::FUNC_PUT && cap_eff != '0 && !hit_reg &&
                    full && vfound_reg;
        do_insert = func_reg == lfu_pkg::FUNC_PUT && cap_eff != '0 && !hit_reg &&
                    (full ? vfound_reg : ffound_reg);
        ins_slot  = full ? vslot_reg : fslot_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg   <= lfu_pkg::CAP_W'(16);
            valid_reg <= '0;
            fill_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (cmd.update) begin
                if (do_insert && !full) begin
                    fill_reg <= fill_reg + 1'b1;
                end
                if (do_insert) begin
                    valid_reg[ins_slot] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            // a put with zero capacity reports no hit even for a held key
            out_hit         <= do_touch;
            out_read_value  <= (hit_reg && func_reg == lfu_pkg::FUNC_GET) ?
                               val_mem_reg[hslot_reg] : lfu_pkg::NEG_ONE;
            out_evicted     <= do_evict;
            out_evicted_key <= do_evict ? key_mem_reg[vslot_reg] : '0;
            for (int i = 0; i < N; i++) begin
                if (do_touch) begin
                    if (lfu_pkg::SLOT_W'(i) == hslot_reg) begin
                        rank_mem_reg[i] <= '0;
                        if (cnt_mem_reg[i] != lfu_pkg::COUNT_MAX) begin
                            cnt_mem_reg[i] <= cnt_mem_reg[i] + 1'b1;
                        end
                        if (func_reg == lfu_pkg::FUNC_PUT) begin
                            val_mem_reg[i] <= wval_reg;
                        end
                    end else if (valid_reg[i] &&
                                 rank_mem_reg[i] < rank_mem_reg[hslot_reg]) begin
                        rank_mem_reg[i] <= rank_mem_reg[i] + 1'b1;
                    end
                end else if (do_insert) begin
                    if (lfu_pkg::SLOT_W'(i) == ins_slot) begin
                        key_mem_reg[i]  <= key_reg;
                        val_mem_reg[i]  <= wval_reg;
                        cnt_mem_reg[i]  <= '0;
                        rank_mem_reg[i] <= '0;
                    end else if (valid_reg[i]) begin
                        // evict removes victim rank and shifts older ones
                        // down; insert then ages all by one
                        if (!do_evict ||
                            rank_mem_reg[i] < rank_mem_reg[vslot_reg]) begin
                            rank_mem_reg[i] <= rank_mem_reg[i] + 1'b1;
                        end
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

[sv/lfu_cache_replacement.sv]
// m_tvalid rises once the accepted input beat has passed the compare,
// search and update steps, in that order.
// The FSM handles one item at a time; a new beat is taken only in idle.
// A result waiting on m_tready holds the update step until it is taken.
// Reset (aresetn low, synchronous): store empty, capacity 16, no result.
// ----------------------------------------------------------------------------
// LFU cache with LRU tie break
// Fully associative 16-entry key/value store, least-frequently-used eviction.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_cache_replacement (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [4:0]  cfg_wr_data,   // capacity_in_use
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [lfu_pkg::TDATA_IN_W-1:0] s_tdata,   // lookup_key[31:0], write_value[63:32]
    input  wire logic        s_tuser,       // func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [lfu_pkg::TDATA_OUT_W-1:0]     m_tdata,   // read_value[31:0], evicted_key[63:32]
    output logic [1:0]       m_tuser        // hit[0], evicted[1]
);

    lfu_pkg::lfu_cmd_t cmd;
    lfu_pkg::lfu_sts_t sts;
    logic              hit, evicted;
    logic [31:0]       rval, ekey;

    lfu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    lfu_dpath u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_func         (s_tuser),
        .in_key          (s_tdata[31:0]),
        .in_value        (s_tdata[63:32]),
        .out_hit         (hit),
        .out_read_value  (rval),
        .out_evicted     (evicted),
        .out_evicted_key (ekey)
    );

    assign m_tdata = {ekey, rval};
    assign m_tuser = {evicted, hit};

endmodule

`default_nettype wire
